// File: hdl/wcg_pkg.sv
// Shared types, constants and latencies for the window coefficient generator.
package wcg_pkg;

  localparam int IDX_W      = 12;
  localparam int LEN_W      = 13;
  localparam int COEF_W     = 18;
  localparam int MAX_LEN    = 4096;
  localparam int PHASE_W    = 24;
  localparam int DIV_STAGES = PHASE_W + 1;

  localparam logic [COEF_W-1:0] COEF_ONE = 18'h20000;
  localparam logic [LEN_W-1:0]  LEN_MAX  = 13'(MAX_LEN);
  localparam logic [LEN_W-1:0]  LEN_RST  = 13'd1024;

  localparam int TAYLOR_TERMS = 7;
  localparam int COS_LAT      = 4 + 2 * TAYLOR_TERMS + 1;
  localparam int ITEM_LAT     = DIV_STAGES + 1 + COS_LAT + 5;

  // round(2*pi*2^30), split for two narrow partial products
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [16:0] TWO_PI_HI  = TWO_PI_Q30[32:16];
  localparam logic [15:0] TWO_PI_LO  = TWO_PI_Q30[15:0];
  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;

  // exact floor division of a 32-bit value by (2k-1)*2k: (p*m) >> shift
  localparam int TAY_SHIFT [1:7] = '{33, 36, 37, 38, 39, 40, 40};
  localparam logic [32:0] TAY_MAGIC [1:7] = '{
    33'(((64'd1 << 33) + 64'd1)   / 64'd2),
    33'(((64'd1 << 36) + 64'd11)  / 64'd12),
    33'(((64'd1 << 37) + 64'd29)  / 64'd30),
    33'(((64'd1 << 38) + 64'd55)  / 64'd56),
    33'(((64'd1 << 39) + 64'd89)  / 64'd90),
    33'(((64'd1 << 40) + 64'd131) / 64'd132),
    33'(((64'd1 << 40) + 64'd181) / 64'd182)
  };

  // window weights scaled by 1e5
  localparam logic signed [48:0] BH_BASE = 49'sd35875 <<< 30;
  localparam logic signed [48:0] W_A1    = 49'sd48829;
  localparam logic signed [48:0] W_A2    = 49'sd14128;
  localparam logic signed [48:0] W_A3    = 49'sd1168;
  localparam logic signed [48:0] W_HANN  = 49'sd50000;
  localparam logic signed [48:0] ONE_Q30 = 49'sd1073741824;

  // divide by 1e5 * 2^13 = 3125 * 2^18, ties up
  localparam logic signed [48:0] ROUND_ADD   = 49'sd409600000;
  localparam int                 ROUND_SHIFT = 18;
  localparam logic [32:0] RECIP_3125 = 33'(((64'd1 << 44) + 64'd3124) / 64'd3125);
  localparam int                 RECIP_SHIFT = 44;

  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_KIND   = 2'd1
  } wcg_reg_t;

  typedef struct packed {
    logic valid;
    logic beyond;
  } wcg_ctl_t;

endpackage

// File: hdl/wcg_phase_div.sv
// Pipelined restoring divider: phase = round(n * 2^24 / d), one quotient bit per stage.
module wcg_phase_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wcg_pkg::wcg_ctl_t                  in_ctl,
  input  logic [wcg_pkg::IDX_W-1:0]          in_n,
  input  logic [wcg_pkg::IDX_W-1:0]          divisor,
  output wcg_pkg::wcg_ctl_t                  out_ctl,
  output logic [wcg_pkg::DIV_STAGES-1:0]     out_quot
);

  localparam int W  = wcg_pkg::IDX_W;
  localparam int QW = wcg_pkg::DIV_STAGES;

  logic [W-1:0]      rem_r  [1:QW];
  logic [QW-1:0]     quot_r [1:QW];
  wcg_pkg::wcg_ctl_t ctl_r  [1:QW];

  // low numerator bits: round-half term d/2
  logic [wcg_pkg::PHASE_W-1:0] half_d;
  assign half_d = wcg_pkg::PHASE_W'(divisor >> 1);

  genvar j;
  generate
    for (j = 0; j < QW; j++) begin : g_stage
      logic [W-1:0]      rem_in;
      logic [QW-1:0]     quot_in;
      wcg_pkg::wcg_ctl_t ctl_in;
      logic              num_bit;
      logic [W:0]        cur;
      logic              ge;
      logic [W-1:0]      rem_nxt;

      if (j == 0) begin : g_first
        // upper numerator bits n >> 1 are already below d
        assign rem_in  = {1'b0, in_n[W-1:1]};
        assign quot_in = '0;
        assign ctl_in  = in_ctl;
        assign num_bit = in_n[0];
      end else begin : g_next
        assign rem_in  = rem_r[j];
        assign quot_in = quot_r[j];
        assign ctl_in  = ctl_r[j];
        assign num_bit = half_d[QW-1-j];
      end

      always_comb begin
        cur     = {rem_in, num_bit};
        ge      = (cur >= {1'b0, divisor});
        rem_nxt = ge ? W'(cur - {1'b0, divisor}) : cur[W-1:0];
      end

      always_ff @(posedge clk) begin
        rem_r[j+1]  <= rem_nxt;
        quot_r[j+1] <= {quot_in[QW-2:0], ge};
        if (!rst_n) begin
          ctl_r[j+1] <= '0;
        end else begin
          ctl_r[j+1] <= ctl_in;
        end
      end
    end
  endgenerate

  assign out_ctl  = ctl_r[QW];
  assign out_quot = quot_r[QW];

endmodule

// File: hdl/wcg_cos.sv
// Pipelined cosine of an angle in turns: quarter-wave fold and Taylor series, Q2.30 out.
module wcg_cos (
  input  logic                              clk,
  input  logic [wcg_pkg::PHASE_W-1:0]       ang,
  output logic signed [31:0]                cos_val
);

  localparam int NT = wcg_pkg::TAYLOR_TERMS;

  // fold
  logic [1:0]  quad;
  logic [22:0] r_nxt;
  logic        neg_nxt;
  logic [22:0] r_r;
  logic        neg0_r;

  always_comb begin
    quad    = ang[23:22];
    r_nxt   = quad[0] ? 23'(23'h400000 - {1'b0, ang[21:0]}) : {1'b0, ang[21:0]};
    neg_nxt = (quad == 2'd1) || (quad == 2'd2);
  end

  // turns to radians in two partial products
  logic [39:0] pp_hi_r;
  logic [38:0] pp_lo_r;
  logic        neg1_r;
  logic [55:0] x_sum;
  logic [30:0] x_r;
  logic        neg2_r;
  logic [61:0] xx;
  logic [31:0] x2_r;
  logic        neg3_r;

  assign x_sum = {pp_hi_r, 16'h0000} + 56'(pp_lo_r) + 56'h80_0000;
  assign xx    = 62'(x_r) * 62'(x_r) + 62'h2000_0000;

  always_ff @(posedge clk) begin
    r_r     <= r_nxt;
    neg0_r  <= neg_nxt;
    pp_hi_r <= 40'(r_r) * 40'(wcg_pkg::TWO_PI_HI);
    pp_lo_r <= 39'(r_r) * 39'(wcg_pkg::TWO_PI_LO);
    neg1_r  <= neg0_r;
    x_r     <= 31'(x_sum >> 24);
    neg2_r  <= neg1_r;
    x2_r    <= 32'(xx >> 30);
    neg3_r  <= neg2_r;
  end

  // series: stage A multiplies by x^2, stage B divides by (2k-1)*2k and accumulates
  logic [31:0]        pa_r   [1:NT];
  logic [31:0]        x2a_r  [1:NT];
  logic signed [34:0] suma_r [1:NT];
  logic               nega_r [1:NT];
  logic [31:0]        term_r [1:NT];
  logic [31:0]        x2b_r  [1:NT];
  logic signed [34:0] sumb_r [1:NT];
  logic               negb_r [1:NT];

  genvar k;
  generate
    for (k = 1; k <= NT; k++) begin : g_term
      logic [31:0]        term_in;
      logic [31:0]        x2_in;
      logic signed [34:0] sum_in;
      logic               neg_in;
      logic [63:0]        pa_prod;
      logic [64:0]        pb_prod;
      logic [31:0]        quo;
      logic signed [34:0] sum_nxt;

      if (k == 1) begin : g_first
        assign term_in = wcg_pkg::Q30_ONE;
        assign x2_in   = x2_r;
        assign sum_in  = $signed({3'b000, wcg_pkg::Q30_ONE});
        assign neg_in  = neg3_r;
      end else begin : g_next
        assign term_in = term_r[k-1];
        assign x2_in   = x2b_r[k-1];
        assign sum_in  = sumb_r[k-1];
        assign neg_in  = negb_r[k-1];
      end

      assign pa_prod = 64'(term_in) * 64'(x2_in);
      assign pb_prod = 65'(pa_r[k]) * 65'(wcg_pkg::TAY_MAGIC[k]);
      assign quo     = 32'(pb_prod >> wcg_pkg::TAY_SHIFT[k]);

      if (k % 2 == 1) begin : g_sub
        assign sum_nxt = suma_r[k] - $signed({3'b000, quo});
      end else begin : g_add
        assign sum_nxt = suma_r[k] + $signed({3'b000, quo});
      end

      always_ff @(posedge clk) begin
        pa_r[k]   <= pa_prod[61:30];
        x2a_r[k]  <= x2_in;
        suma_r[k] <= sum_in;
        nega_r[k] <= neg_in;
        term_r[k] <= quo;
        x2b_r[k]  <= x2a_r[k];
        sumb_r[k] <= sum_nxt;
        negb_r[k] <= nega_r[k];
      end
    end
  endgenerate

  // clamp to [-1, 1], then apply quadrant sign
  logic signed [34:0] s_fin;
  logic signed [31:0] c_clamp;
  logic signed [31:0] cos_r;

  always_comb begin
    s_fin = sumb_r[NT];
    if (s_fin > 35'sd1073741824) begin
      c_clamp = 32'sd1073741824;
    end else if (s_fin < -35'sd1073741824) begin
      c_clamp = -32'sd1073741824;
    end else begin
      c_clamp = 32'(s_fin);
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= negb_r[NT] ? -c_clamp : c_clamp;
  end

  assign cos_val = cos_r;

endmodule

// File: hdl/window_coefficient_generator.sv
// Top level: Hann / 4-term Blackman-Harris window coefficient per sample index.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-------------------------------
//  input    | in_sample_index[11:0]                        | start & !busy at clk edge
//  result   | out_coefficient[17:0], out_index_beyond_length | out_strobe, one cycle
//  config   | cfg_index[1:0], cfg_wdata[12:0]              | cfg_we at clk edge
//
//  One item per clock while busy is low; every item passes in order through the
//  25-stage divider, 1 phase-multiple stage, 19-stage cosine and 5 weighting stages.
//  busy is high only in the cycle after reset; otherwise the pipeline always accepts.
//  rst_n is synchronous, active low; it clears valid bits and presets config to 1024, Hann.
//  The receiver cannot stall, so nothing in the pipeline ever holds.
module window_coefficient_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [wcg_pkg::IDX_W-1:0]       in_sample_index,
  output logic                            out_strobe,
  output logic [wcg_pkg::COEF_W-1:0]      out_coefficient,
  output logic                            out_index_beyond_length,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [wcg_pkg::LEN_W-1:0]       cfg_wdata
);

  localparam int CL = wcg_pkg::COS_LAT;

  // ---------------- configuration ----------------
  logic [wcg_pkg::LEN_W-1:0] len_r;
  logic                      kind_r;
  logic                      busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= wcg_pkg::LEN_RST;
      kind_r <= 1'b0;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          wcg_pkg::REG_LENGTH: len_r  <= cfg_wdata;
          wcg_pkg::REG_KIND:   kind_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // effective length, divisor d=N-1: user keeps stable while items are in flight, unchecked
  logic [wcg_pkg::LEN_W-1:0] len_eff;
  logic [wcg_pkg::IDX_W-1:0] divisor;
  logic                      d_zero;

  assign len_eff = (len_r > wcg_pkg::LEN_MAX) ? wcg_pkg::LEN_MAX : len_r;
  assign divisor = wcg_pkg::IDX_W'(len_eff - 13'd1);
  assign d_zero  = (len_eff < 13'd2);

  // ---------------- phase division ----------------
  wcg_pkg::wcg_ctl_t              in_ctl;
  wcg_pkg::wcg_ctl_t              div_ctl;
  logic [wcg_pkg::DIV_STAGES-1:0] div_quot;

  assign in_ctl.valid  = start && !busy;
  assign in_ctl.beyond = ({1'b0, in_sample_index} >= len_eff);

  wcg_phase_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (in_ctl),
    .in_n     (in_sample_index),
    .divisor  (divisor),
    .out_ctl  (div_ctl),
    .out_quot (div_quot)
  );

  // ---------------- phase multiples p, 2p, 3p mod one turn ----------------
  logic [wcg_pkg::PHASE_W-1:0] ph1;
  logic [wcg_pkg::PHASE_W-1:0] ph1_r;
  logic [wcg_pkg::PHASE_W-1:0] ph2_r;
  logic [wcg_pkg::PHASE_W-1:0] ph3_r;
  wcg_pkg::wcg_ctl_t           ctl_ph_r;

  // a one-point window divides by zero; its only index uses phase 0
  assign ph1 = d_zero ? '0 : div_quot[wcg_pkg::PHASE_W-1:0];

  always_ff @(posedge clk) begin
    ph1_r <= ph1;
    ph2_r <= {ph1[wcg_pkg::PHASE_W-2:0], 1'b0};
    ph3_r <= wcg_pkg::PHASE_W'(ph1 + {ph1[wcg_pkg::PHASE_W-2:0], 1'b0});
    if (!rst_n) begin
      ctl_ph_r <= '0;
    end else begin
      ctl_ph_r <= div_ctl;
    end
  end

  // ---------------- three cosines in parallel ----------------
  logic signed [31:0] cos1;
  logic signed [31:0] cos2;
  logic signed [31:0] cos3;

  wcg_cos u_cos1 (.clk(clk), .ang(ph1_r), .cos_val(cos1));
  wcg_cos u_cos2 (.clk(clk), .ang(ph2_r), .cos_val(cos2));
  wcg_cos u_cos3 (.clk(clk), .ang(ph3_r), .cos_val(cos3));

  // control rides alongside the cosine pipeline
  wcg_pkg::wcg_ctl_t ctl_cos_r [0:CL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CL; i++) begin
        ctl_cos_r[i] <= '0;
      end
    end else begin
      ctl_cos_r[0] <= ctl_ph_r;
      for (int i = 1; i < CL; i++) begin
        ctl_cos_r[i] <= ctl_cos_r[i-1];
      end
    end
  end

  // ---------------- weighting ----------------
  // F1: weight products
  logic signed [48:0] m1_r;
  logic signed [48:0] m2_r;
  logic signed [48:0] m3_r;
  logic signed [48:0] hann_r;
  // F2: window sum, scaled by 1e5 * 2^30
  logic signed [48:0] w_nxt;
  logic signed [48:0] w_r;
  // F3: round and drop the power-of-two part of the divisor
  logic [31:0]        v_r;
  logic               pos_r;
  // F4: divide by 3125 via reciprocal
  logic [64:0]        rq_prod;
  logic [19:0]        q_r;
  logic               pos4_r;

  wcg_pkg::wcg_ctl_t  ctl_f_r [0:3];

  assign w_nxt = kind_r ? (wcg_pkg::BH_BASE - m1_r + m2_r - m3_r) : hann_r;
  assign rq_prod = 65'(v_r) * 65'(wcg_pkg::RECIP_3125);

  always_ff @(posedge clk) begin
    m1_r   <= 49'(cos1) * wcg_pkg::W_A1;
    m2_r   <= 49'(cos2) * wcg_pkg::W_A2;
    m3_r   <= 49'(cos3) * wcg_pkg::W_A3;
    hann_r <= (wcg_pkg::ONE_Q30 - 49'(cos1)) * wcg_pkg::W_HANN;
    w_r    <= w_nxt;
    v_r    <= 32'((w_r + wcg_pkg::ROUND_ADD) >>> wcg_pkg::ROUND_SHIFT);
    pos_r  <= (w_r > 49'sd0);
    q_r    <= 20'(rq_prod >> wcg_pkg::RECIP_SHIFT);
    pos4_r <= pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        ctl_f_r[i] <= '0;
      end
    end else begin
      ctl_f_r[0] <= ctl_cos_r[CL-1];
      for (int i = 1; i < 4; i++) begin
        ctl_f_r[i] <= ctl_f_r[i-1];
      end
    end
  end

  // ---------------- output register ----------------
  logic [wcg_pkg::COEF_W-1:0] coef_nxt;
  logic [wcg_pkg::COEF_W-1:0] coef_r;
  logic                       strobe_r;
  logic                       beyond_r;

  // negative window clamps to 0, overshoot clamps to 1.0, out-of-range index gives 0
  always_comb begin
    if (ctl_f_r[3].beyond || !pos4_r) begin
      coef_nxt = '0;
    end else if (q_r > {2'b00, wcg_pkg::COEF_ONE}) begin
      coef_nxt = wcg_pkg::COEF_ONE;
    end else begin
      coef_nxt = q_r[wcg_pkg::COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    coef_r   <= coef_nxt;
    beyond_r <= ctl_f_r[3].beyond;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_f_r[3].valid;
    end
  end

  assign out_strobe              = strobe_r;
  assign out_coefficient         = coef_r;
  assign out_index_beyond_length = beyond_r;

`ifndef NO_ASSERTIONS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(wcg_pkg::ITEM_LAT) out_strobe)
    else $error("accepted item did not produce a result on time");

  a_no_orphan : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, wcg_pkg::ITEM_LAT))
    else $error("result without a matching accepted item");

  a_beyond_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_index_beyond_length) |-> (out_coefficient == '0))
    else $error("out-of-range index gave a nonzero coefficient");

  a_clamp : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_coefficient <= wcg_pkg::COEF_ONE))
    else $error("coefficient above 1.0");
`endif

endmodule

// File: bench/window_coefficient_generator_test.sv
// Testbench for the window coefficient generator: scoreboard class plus driver tasks.
`timescale 1ns / 100ps

module window_coefficient_generator_test;

  // expected coefficient store with its own window arithmetic
  class window_scoreboard;
    logic [wcg_pkg::LEN_W-1:0] length_reg;
    logic             kind_reg;
    logic [wcg_pkg::COEF_W-1:0] coef_q[$];
    logic              beyond_q[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function void reset_regs();
      length_reg = wcg_pkg::LEN_RST;
      kind_reg   = 1'b0;
    endfunction

    function void write_reg(wcg_pkg::wcg_reg_t idx, logic [wcg_pkg::LEN_W-1:0] val);
      if (idx == wcg_pkg::REG_LENGTH) length_reg = val;
      else if (idx == wcg_pkg::REG_KIND) kind_reg = val[0];
    endfunction

    // cosine of a Q0.24 turn angle, signed Q2.30
    function longint cos_of_turns(longint unsigned a);
      longint unsigned ph, quad, r, x, x2, term;
      longint acc;
      ph   = a & 64'hFF_FFFF;
      quad = ph >> 22;
      r    = ph & 64'h3F_FFFF;
      if (quad == 1 || quad == 3) r = (64'd1 << 22) - r;
      x  = (r * 64'd6746518852 + (64'd1 << 23)) >> 24;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      acc  = 64'sd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
        if (k & 1) acc -= longint'(term);
        else       acc += longint'(term);
      end
      if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
      if (acc < -(64'sd1 << 30)) acc = -(64'sd1 << 30);
      return (quad == 1 || quad == 2) ? -acc : acc;
    endfunction

    function void note_index(logic [wcg_pkg::IDX_W-1:0] n);
      longint unsigned len, d, ph, c;
      longint w;
      len = length_reg;
      if (len > wcg_pkg::MAX_LEN) len = wcg_pkg::MAX_LEN;
      if (n >= len) begin
        coef_q.push_back('0);
        beyond_q.push_back(1'b1);
        return;
      end
      ph = 0;
      if (len >= 2) begin
        d  = len - 1;
        ph = ((longint'(n) << 24) + d / 2) / d;
      end
      if (kind_reg)
        w = 35875 * (64'sd1 << 30) - 48829 * cos_of_turns(ph)
            + 14128 * cos_of_turns(2 * ph) - 1168 * cos_of_turns(3 * ph);
      else
        w = 50000 * ((64'sd1 << 30) - cos_of_turns(ph));
      if (w <= 0) c = 0;
      else begin
        c = (longint'(w) + 64'd409600000) / 64'd819200000;
        if (c > (1 << 17)) c = 1 << 17;
      end
      coef_q.push_back(c[wcg_pkg::COEF_W-1:0]);
      beyond_q.push_back(1'b0);
    endfunction

    function void check_result(logic [wcg_pkg::COEF_W-1:0] coef, logic beyond);
      logic [wcg_pkg::COEF_W-1:0] exp_c;
      logic exp_b;
      results_seen++;
      if (coef_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result coef=%0d flag=%0b", coef, beyond);
        return;
      end
      exp_c = coef_q.pop_front();
      exp_b = beyond_q.pop_front();
      if (coef !== exp_c || beyond !== exp_b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected coef=%0d flag=%0b, got coef=%0d flag=%0b",
                   exp_c, exp_b, coef, beyond);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [wcg_pkg::IDX_W-1:0] in_sample_index = '0;
  logic out_strobe;
  logic [wcg_pkg::COEF_W-1:0] out_coefficient;
  logic out_index_beyond_length;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [wcg_pkg::LEN_W-1:0] cfg_wdata = '0;

  window_scoreboard coef_board = new();
  int unsigned idle_pct;   // chance of a gap before each item
  int unsigned items_sent;

  always #5 clk = ~clk;

  window_coefficient_generator i_dut (
    .clk, .rst_n, .start, .busy, .in_sample_index,
    .out_strobe, .out_coefficient, .out_index_beyond_length,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  // results can't be held off: check on every strobed edge
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      coef_board.check_result(out_coefficient, out_index_beyond_length);
  end

  // present one index; hold start until an edge with busy low takes it
  task automatic send_index(logic [wcg_pkg::IDX_W-1:0] n);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_sample_index <= n;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      if (taken) coef_board.note_index(n);
      @(negedge clk);
    end
    items_sent++;
  endtask

  // drain the pipeline so that register writes find it idle
  task automatic drain();
    start <= 1'b0;
    while (coef_board.coef_q.size() != 0) @(negedge clk);
    repeat (wcg_pkg::ITEM_LAT + 5) @(negedge clk);
  endtask

  task automatic write_reg(wcg_pkg::wcg_reg_t idx, logic [wcg_pkg::LEN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    coef_board.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(logic [wcg_pkg::LEN_W-1:0] len, logic kind);
    drain();
    write_reg(wcg_pkg::REG_LENGTH, len);
    write_reg(wcg_pkg::REG_KIND, {12'd0, kind});
  endtask

  // random phase: mostly in-range indexes, some beyond the length
  task automatic random_run(int count);
    int unsigned lim;
    for (int i = 0; i < count; i++) begin
      lim = coef_board.length_reg > wcg_pkg::MAX_LEN ? wcg_pkg::MAX_LEN
                                                     : coef_board.length_reg;
      if (lim != 0 && $urandom_range(9) < 8)
        send_index(wcg_pkg::IDX_W'($urandom_range(lim - 1)));
      else
        send_index(wcg_pkg::IDX_W'($urandom_range(4095)));
    end
  endtask

  initial begin
    coef_board.reset_regs();
    idle_pct = 0;
    items_sent = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset window, edges of the index, both kinds, odd lengths
    send_index(12'd0); send_index(12'd511); send_index(12'd1023); send_index(12'd1024);
    send_index(12'd4095); send_index(12'hAAA); send_index(12'h555);
    set_window(13'd4096, 1'b1);
    send_index(12'd0); send_index(12'd2048); send_index(12'd4095); send_index(12'd1365);
    set_window(13'd2, 1'b0);
    send_index(12'd0); send_index(12'd1); send_index(12'd2);
    set_window(13'd1, 1'b1);          // single point: phase zero
    send_index(12'd0); send_index(12'd1);
    set_window(13'd0, 1'b0);          // empty window: all beyond
    send_index(12'd0); send_index(12'd4095);
    set_window(13'h1FFF, 1'b1);       // above maximum: clipped to 4096
    send_index(12'd4095); send_index(12'd1000);

    // random phases over several settings and idling mixes
    idle_pct = 0;  set_window(13'd1024, 1'b0); random_run(70);
    idle_pct = 64; set_window(13'd4096, 1'b1); random_run(70);
    idle_pct = 0;  set_window(13'd3, 1'b1);    random_run(40);
    idle_pct = 9;  set_window(13'd2, 1'b1);    random_run(30);
    idle_pct = 64; set_window(13'($urandom_range(4, 4095)), 1'b0); random_run(70);
    idle_pct = 9;  set_window(13'($urandom_range(4096, 8191)), 1'b0); random_run(50);
    idle_pct = 0;  set_window(13'($urandom_range(2, 300)), 1'b1); random_run(70);

    drain();
    $display("Covered %0d indexes over Hann and Blackman-Harris windows, lengths 0 to 8191,",
             items_sent);
    $display("with and without sender gaps; %0d results checked, %0d mismatches.",
             coef_board.results_seen, coef_board.mismatches);
    if (coef_board.mismatches == 0 && coef_board.coef_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
hdl/wcg_pkg.sv
hdl/wcg_phase_div.sv
hdl/wcg_cos.sv
hdl/window_coefficient_generator.sv
bench/window_coefficient_generator_test.sv
